/* src/lru_variable_size_pool_cache_macros.svh */
// Assertion macros for the LRU variable size pool cache.
`ifndef LRU_VARIABLE_SIZE_POOL_CACHE_MACROS_SVH
`define LRU_VARIABLE_SIZE_POOL_CACHE_MACROS_SVH

// Clocked check, muted while reset is applied.
`define LVC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check on the clock, muted while reset is applied.
`define LVC_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

/* src/lvc_pkg.sv */
// Package: types and constants of the LRU variable size pool cache.
`default_nettype none
package lvc_pkg;
  localparam int SLOTS = 8;
  localparam int SW = 3;
  localparam int KEY_BITS_DEF = 64;
  localparam logic [17:0] POOL_MAX_BYTES = 18'd131072;
  localparam logic [17:0] POOL_RESET = 18'd1024;
  localparam logic [17:0] MAXOBJ_RESET = 18'd512;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    REG_POOL   = 1'b0,
    REG_MAXOBJ = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;
endpackage
`default_nettype wire

/* src/lvc_scan.sv */
// Shared compare unit: tracks the first or smallest qualifying slot over a scan.
`default_nettype none
module lvc_scan
  import lvc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scan_ctl_t     ctl,
  input  wire logic          cand_ok,
  input  wire logic [31:0]   cand_val,
  input  wire logic [SW-1:0] cand_idx,
  output logic               found,
  output logic [SW-1:0]      best_idx
);
  logic          found_r;
  logic [SW-1:0] best_idx_r;
  logic [31:0]   best_val_r;
  logic          have;
  logic          take;

  assign have = ctl.clr ? 1'b0 : found_r;
  assign take = cand_ok && (!have || (cand_val < best_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.en) begin
      found_r <= have || take;
      if (take) begin
        best_idx_r <= cand_idx;
        best_val_r <= cand_val;
      end
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
endmodule
`default_nettype wire

/* src/lru_variable_size_pool_cache.sv */
// Top level of the LRU variable size pool cache metadata engine.
`default_nettype none
`include "lru_variable_size_pool_cache_macros.svh"
// One request is taken while busy is low; busy stays high until its final
// result is driven. Every slot scan walks the eight slots one per cycle
// through one shared compare unit, then takes a closing step. A lookup
// makes one scan; an insert makes one scan per eviction and, when evictions
// force a repack, repacks with one scan per surviving entry and a closing
// scan, as does an invalidate of a valid slot. Results come out as one-cycle
// out_strobe beats (move commands, then the final result with out_last) and
// cannot be stalled. cfg_ready is always high; write configuration only
// while busy is low.
module lru_variable_size_pool_cache
  import lvc_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_obj_key,
  input  wire logic [17:0] in_obj_length,
  input  wire logic [31:0] in_now_tick,
  input  wire logic [2:0]  in_target_slot,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [2:0]       out_slot,
  output logic [16:0]      out_offset,
  output logic [16:0]      out_src_offset,
  output logic [17:0]      out_length,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count,
  output logic [17:0]      out_bytes_used,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_INS_CHK, S_EV_TEST, S_FREE_TEST, S_PLACE, S_FINAL
  } state_t;
  typedef enum logic [1:0] {P_LOOK, P_EVICT, P_EVONE, P_REPACK} purpose_t;

  state_t        state_r;
  purpose_t      purp_r;
  logic [SW-1:0] idx_r;
  logic [17:0]   pool_r, maxobj_r;
  logic [SLOTS-1:0] valid_r, done_r;
  logic [KEY_BITS-1:0] key_mem [SLOTS];
  logic [16:0]   off_mem [SLOTS];
  logic [17:0]   len_mem [SLOTS];
  logic [31:0]   tick_mem [SLOTS];
  logic [17:0]   used_r, wr_r;
  logic [31:0]   hits_r, miss_r;
  action_t       act_r;
  logic [KEY_BITS-1:0] key_r;
  logic [17:0]   len_r;
  logic [31:0]   tick_r;
  logic          evicted_r;
  logic [SW-1:0] sel_r;
  logic [1:0]    st_r;
  logic [SW-1:0] rslot_r;
  logic [16:0]   roff_r;
  logic [17:0]   rlen_r;

  scan_ctl_t     sctl;
  logic          cand_ok;
  logic [31:0]   cand_val;
  logic          s_found;
  logic [SW-1:0] s_idx;
  logic [17:0]   pool_eff;
  logic [18:0]   need;
  logic          any_free;
  logic [SW-1:0] free_idx;

  assign pool_eff = (pool_r > POOL_MAX_BYTES) ? POOL_MAX_BYTES : pool_r;
  assign need = {1'b0, used_r} + {1'b0, len_r};
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    sctl.en  = (state_r == S_SCAN);
    sctl.clr = (idx_r == '0);
    case (purp_r)
      P_LOOK: begin
        cand_ok  = valid_r[idx_r] && (key_mem[idx_r] == key_r);
        cand_val = '0;
      end
      P_REPACK: begin
        cand_ok  = valid_r[idx_r] && !done_r[idx_r];
        cand_val = {15'd0, off_mem[idx_r]};
      end
      default: begin
        cand_ok  = valid_r[idx_r];
        cand_val = tick_mem[idx_r];
      end
    endcase
  end

  lvc_scan u_scan (
    .clk(clk), .rst_n(rst_n), .ctl(sctl), .cand_ok(cand_ok), .cand_val(cand_val),
    .cand_idx(idx_r), .found(s_found), .best_idx(s_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      purp_r     <= P_LOOK;
      idx_r      <= '0;
      valid_r    <= '0;
      done_r     <= '0;
      used_r     <= '0;
      hits_r     <= '0;
      miss_r     <= '0;
      pool_r     <= POOL_RESET;
      maxobj_r   <= MAXOBJ_RESET;
      out_strobe <= 1'b0;
      evicted_r  <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_POOL:   pool_r   <= cfg_data;
          REG_MAXOBJ: maxobj_r <= cfg_data;
          default:    pool_r   <= pool_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r     <= action_t'(in_action);
            key_r     <= in_obj_key[KEY_BITS-1:0];
            len_r     <= in_obj_length;
            tick_r    <= in_now_tick;
            st_r      <= ST_OK;
            rslot_r   <= '0;
            roff_r    <= '0;
            rlen_r    <= '0;
            evicted_r <= 1'b0;
            idx_r     <= '0;
            case (action_t'(in_action))
              ACT_LOOKUP: begin
                purp_r  <= P_LOOK;
                state_r <= S_SCAN;
              end
              ACT_INSERT: state_r <= S_INS_CHK;
              ACT_INVAL: begin
                rslot_r <= in_target_slot;
                if (valid_r[in_target_slot]) begin
                  roff_r  <= off_mem[in_target_slot];
                  rlen_r  <= len_mem[in_target_slot];
                  valid_r[in_target_slot] <= 1'b0;
                  used_r  <= used_r - len_mem[in_target_slot];
                  purp_r  <= P_REPACK;
                  done_r  <= '0;
                  wr_r    <= '0;
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_FINAL;
                end
              end
              default: begin
                valid_r <= '0;
                used_r  <= '0;
                state_r <= S_FINAL;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + SW'(1);
          if (idx_r == SW'(SLOTS - 1)) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          idx_r <= '0;
          case (purp_r)
            P_LOOK: begin
              if (s_found) begin
                tick_mem[s_idx] <= tick_r;
                hits_r  <= hits_r + 32'd1;
                rslot_r <= s_idx;
                roff_r  <= off_mem[s_idx];
                rlen_r  <= len_mem[s_idx];
              end else begin
                miss_r <= miss_r + 32'd1;
                st_r   <= ST_MISS;
              end
              state_r <= S_FINAL;
            end
            P_REPACK: begin
              if (s_found) begin
                done_r[s_idx] <= 1'b1;
                if (off_mem[s_idx] != wr_r[16:0]) begin
                  out_strobe     <= 1'b1;
                  out_kind       <= 1'b0;
                  out_last       <= 1'b0;
                  out_status     <= ST_OK;
                  out_slot       <= s_idx;
                  out_offset     <= wr_r[16:0];
                  out_src_offset <= off_mem[s_idx];
                  out_length     <= len_mem[s_idx];
                  out_hit_count  <= hits_r;
                  out_miss_count <= miss_r;
                  out_bytes_used <= (act_r == ACT_INSERT) ? used_r + len_r : used_r;
                  off_mem[s_idx] <= wr_r[16:0];
                end
                wr_r    <= wr_r + len_mem[s_idx];
                state_r <= S_SCAN;
              end else begin
                state_r <= (act_r == ACT_INSERT) ? S_PLACE : S_FINAL;
              end
            end
            default: begin
              if (s_found) begin
                valid_r[s_idx] <= 1'b0;
                used_r    <= used_r - len_mem[s_idx];
                evicted_r <= 1'b1;
              end
              state_r <= (purp_r == P_EVICT && s_found) ? S_EV_TEST : S_FREE_TEST;
            end
          endcase
        end
        S_INS_CHK: begin
          if (len_r == '0 || len_r > maxobj_r || len_r > pool_eff) begin
            st_r    <= ST_REJECT;
            state_r <= S_FINAL;
          end else begin
            state_r <= S_EV_TEST;
          end
        end
        S_EV_TEST: begin
          if (need > {1'b0, pool_eff}) begin
            purp_r  <= P_EVICT;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_FREE_TEST;
          end
        end
        S_FREE_TEST: begin
          if (any_free) begin
            sel_r <= free_idx;
            if (evicted_r) begin
              purp_r  <= P_REPACK;
              done_r  <= '0;
              wr_r    <= '0;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_PLACE;
            end
          end else begin
            purp_r  <= P_EVONE;
            state_r <= S_SCAN;
          end
        end
        S_PLACE: begin
          valid_r[sel_r]  <= 1'b1;
          key_mem[sel_r]  <= key_r;
          off_mem[sel_r]  <= used_r[16:0];
          len_mem[sel_r]  <= len_r;
          tick_mem[sel_r] <= tick_r;
          used_r          <= used_r + len_r;
          rslot_r         <= sel_r;
          roff_r          <= used_r[16:0];
          rlen_r          <= len_r;
          state_r         <= S_FINAL;
        end
        S_FINAL: begin
          out_strobe     <= 1'b1;
          out_kind       <= 1'b1;
          out_last       <= 1'b1;
          out_status     <= st_r;
          out_slot       <= rslot_r;
          out_offset     <= roff_r;
          out_src_offset <= '0;
          out_length     <= rlen_r;
          out_hit_count  <= hits_r;
          out_miss_count <= miss_r;
          out_bytes_used <= used_r;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LVC_IMPLY(a_take_busy, start && !busy, ##1 busy, "accepted request must raise busy")
  `LVC_IMPLY(a_last_kind, out_strobe && out_last, out_kind, "final beat must be a result")
  `LVC_CHECK(a_used_max, used_r <= POOL_MAX_BYTES, "pool usage above maximum")
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the LRU pool cache: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_top
  import lvc_pkg::*;
;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [16:0] offset;
    logic [16:0] src_offset;
    logic [17:0] length;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [17:0] bytes_used;
    logic        last;
  } cache_beat_t;

  typedef struct {
    action_t     act;
    logic [63:0] key;
    logic [17:0] len;
    logic [31:0] tick;
    logic [2:0]  tgt;
    bit          typed;
    status_t     st;
    logic [2:0]  slot;
    logic [16:0] off;
    logic [17:0] ln;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [63:0] in_obj_key = '0;
  logic [17:0] in_obj_length = '0;
  logic [31:0] in_now_tick = '0;
  logic [2:0] in_target_slot = '0;
  logic out_strobe, out_kind, out_last;
  logic [1:0] out_status;
  logic [2:0] out_slot;
  logic [16:0] out_offset, out_src_offset;
  logic [17:0] out_length, out_bytes_used;
  logic [31:0] out_hit_count, out_miss_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  lru_variable_size_pool_cache uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_obj_key(in_obj_key), .in_obj_length(in_obj_length),
    .in_now_tick(in_now_tick), .in_target_slot(in_target_slot),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_status(out_status),
    .out_slot(out_slot), .out_offset(out_offset), .out_src_offset(out_src_offset),
    .out_length(out_length), .out_hit_count(out_hit_count),
    .out_miss_count(out_miss_count), .out_bytes_used(out_bytes_used),
    .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache model state
  bit          m_valid [SLOTS];
  logic [63:0] m_key   [SLOTS];
  int unsigned m_off   [SLOTS];
  int unsigned m_len   [SLOTS];
  logic [31:0] m_tick  [SLOTS];
  int unsigned m_used;
  logic [31:0] m_hits, m_misses;
  int unsigned m_pool_cfg = POOL_RESET;
  int unsigned m_maxobj_cfg = MAXOBJ_RESET;

  cache_beat_t beats_now[$];
  cache_beat_t pending_beats[$];
  int errors = 0;
  int cycles = 0;
  logic [63:0] key_set[16];
  logic [31:0] tick_now = 32'd100;
  bit allow_gaps = 1'b1;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit evict_lru();
    int best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && (best < 0 || m_tick[i] < m_tick[best])) best = i;
    if (best < 0) return 1'b0;
    m_valid[best] = 1'b0;
    m_used -= m_len[best];
    return 1'b1;
  endfunction

  function automatic void add_beat(logic kind, status_t st, int slot, int unsigned off,
                                   int unsigned src, int unsigned len, logic last);
    cache_beat_t b;
    b.kind = kind; b.status = st; b.slot = slot[2:0]; b.offset = off[16:0];
    b.src_offset = src[16:0]; b.length = len[17:0]; b.hit_count = m_hits;
    b.miss_count = m_misses; b.bytes_used = '0; b.last = last;
    beats_now.push_back(b);
  endfunction

  function automatic void compact_pool();
    bit done [SLOTS];
    int unsigned wr = 0;
    int best;
    foreach (done[i]) done[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (m_valid[i] && !done[i] && (best < 0 || m_off[i] < m_off[best])) best = i;
      if (best < 0) break;
      done[best] = 1'b1;
      if (m_off[best] != wr) begin
        add_beat(1'b0, ST_OK, best, wr, m_off[best], m_len[best], 1'b0);
        m_off[best] = wr;
      end
      wr += m_len[best];
    end
    m_used = wr;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++) if (!m_valid[i]) return i;
    return -1;
  endfunction

  function automatic void model_request(req_row_t r);
    int unsigned pool = (m_pool_cfg > POOL_MAX_BYTES) ? POOL_MAX_BYTES : m_pool_cfg;
    status_t st = ST_OK;
    int rslot = 0;
    int unsigned roff = 0, rlen = 0, len = r.len;
    int found = -1, s;
    bit evicted = 1'b0;
    beats_now.delete();
    case (r.act)
      ACT_LOOKUP: begin
        for (int i = 0; i < SLOTS; i++)
          if (found < 0 && m_valid[i] && m_key[i] == r.key) found = i;
        if (found >= 0) begin
          m_tick[found] = r.tick;
          m_hits++;
          rslot = found; roff = m_off[found]; rlen = m_len[found];
        end else begin
          m_misses++;
          st = ST_MISS;
        end
      end
      ACT_INSERT: begin
        if (len == 0 || len > m_maxobj_cfg || len > pool) begin
          st = ST_REJECT;
        end else begin
          while (m_used + len > pool && evict_lru()) evicted = 1'b1;
          s = first_free();
          if (s < 0) begin
            if (evict_lru()) evicted = 1'b1;
            s = first_free();
          end
          if (evicted) compact_pool();
          if (s < 0 || m_used + len > pool) begin
            st = ST_REJECT;
          end else begin
            m_valid[s] = 1'b1; m_key[s] = r.key; m_off[s] = m_used;
            m_len[s] = len; m_tick[s] = r.tick;
            m_used += len;
            rslot = s; roff = m_off[s]; rlen = len;
          end
        end
      end
      ACT_INVAL: begin
        rslot = r.tgt;
        if (m_valid[r.tgt]) begin
          roff = m_off[r.tgt]; rlen = m_len[r.tgt];
          m_valid[r.tgt] = 1'b0;
          compact_pool();
        end
      end
      default: begin
        foreach (m_valid[i]) m_valid[i] = 1'b0;
        m_used = 0;
      end
    endcase
    add_beat(1'b1, st, rslot, roff, 0, rlen, 1'b1);
    if (r.typed) begin
      beats_now[$].status = r.st; beats_now[$].slot = r.slot;
      beats_now[$].offset = r.off; beats_now[$].length = r.ln;
    end
    foreach (beats_now[i]) begin
      beats_now[i].bytes_used = m_used[17:0];
      pending_beats.push_back(beats_now[i]);
    end
  endfunction

  always @(posedge clk) begin
    cache_beat_t w;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        report("unexpected beat", out_kind, 0);
      end else begin
        w = pending_beats.pop_front();
        if (out_kind !== w.kind) report("kind", out_kind, w.kind);
        if (out_status !== w.status) report("status", out_status, w.status);
        if (out_slot !== w.slot) report("slot", out_slot, w.slot);
        if (out_offset !== w.offset) report("offset", out_offset, w.offset);
        if (out_src_offset !== w.src_offset) report("src_offset", out_src_offset, w.src_offset);
        if (out_length !== w.length) report("length", out_length, w.length);
        if (out_hit_count !== w.hit_count) report("hit_count", out_hit_count, w.hit_count);
        if (out_miss_count !== w.miss_count)
          report("miss_count", out_miss_count, w.miss_count);
        if (out_bytes_used !== w.bytes_used)
          report("bytes_used", out_bytes_used, w.bytes_used);
        if (out_last !== w.last) report("last", out_last, w.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(req_row_t r);
    @(negedge clk);
    in_action = r.act; in_obj_key = r.key; in_obj_length = r.len;
    in_now_tick = r.tick; in_target_slot = r.tgt; start = 1'b1;
    do @(posedge clk); while (busy);
    model_request(r);
  endtask

  task automatic maybe_gap();
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [17:0] data);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_POOL) m_pool_cfg = data; else m_maxobj_cfg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_row_t mk(action_t a, logic [63:0] k, logic [17:0] l,
                                  logic [31:0] t, logic [2:0] g);
    req_row_t r;
    r.act = a; r.key = k; r.len = l; r.tick = t; r.tgt = g; r.typed = 1'b0;
    r.st = ST_OK; r.slot = '0; r.off = '0; r.ln = '0;
    return r;
  endfunction

  function automatic req_row_t typed(req_row_t r, status_t st, logic [2:0] s,
                                     logic [16:0] o, logic [17:0] l);
    r.typed = 1'b1; r.st = st; r.slot = s; r.off = o; r.ln = l;
    return r;
  endfunction

  function automatic req_row_t rand_req();
    int unsigned pool = (m_pool_cfg > POOL_MAX_BYTES) ? POOL_MAX_BYTES : m_pool_cfg;
    int unsigned sel = $urandom_range(0, 99);
    int unsigned cap = (pool < m_maxobj_cfg) ? pool : m_maxobj_cfg;
    req_row_t r;
    logic [17:0] len;
    tick_now += $urandom_range(0, 3);
    if ($urandom_range(0, 19) == 0) tick_now = $urandom;
    case ($urandom_range(0, 9))
      0: len = 18'($urandom_range(0, 131072));
      1: len = (cap > 0) ? 18'(cap) : 18'd1;
      2: len = 18'd131072;
      default: len = 18'($urandom_range(1, cap / 3 + 1));
    endcase
    if (sel < 40) r = mk(ACT_INSERT, key_set[$urandom_range(0, 15)], len, tick_now, 3'd0);
    else if (sel < 75)
      r = mk(ACT_LOOKUP, ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
             : key_set[$urandom_range(0, 15)], 18'($urandom_range(0, 131072)),
             tick_now, 3'd0);
    else if (sel < 96)
      r = mk(ACT_INVAL, {$urandom, $urandom}, 18'($urandom_range(0, 131072)), tick_now,
             3'($urandom_range(0, 7)));
    else r = mk(ACT_CLEAR, {$urandom, $urandom}, 18'($urandom_range(0, 131072)),
                tick_now, 3'($urandom_range(0, 7)));
    return r;
  endfunction

  initial begin
    req_row_t rows[$];
    logic [17:0] pool_set[6];
    logic [17:0] maxobj_set[6];
    foreach (key_set[i]) key_set[i] = {$urandom, $urandom};
    key_set[0] = '1;
    key_set[1] = '0;
    pool_set = '{18'd131072, 18'h3FFFF, 18'd1, 18'd64, 18'd700, 18'd1024};
    maxobj_set = '{18'd131072, 18'd1, 18'h3FFFF, 18'd40, 18'd300, 18'd512};

    rows.push_back(typed(mk(ACT_LOOKUP, '0, 0, 0, 0), ST_MISS, 0, 0, 0));
    rows.push_back(typed(mk(ACT_INSERT, 64'h5, 0, 1, 0), ST_REJECT, 0, 0, 0));
    rows.push_back(typed(mk(ACT_INSERT, 64'h5, 513, 1, 0), ST_REJECT, 0, 0, 0));
    rows.push_back(typed(mk(ACT_INSERT, '1, 512, '1, 0), ST_OK, 0, 0, 512));
    rows.push_back(typed(mk(ACT_INSERT, '0, 512, 5, 7), ST_OK, 1, 512, 512));
    rows.push_back(typed(mk(ACT_LOOKUP, '1, 0, 1, 0), ST_OK, 0, 0, 512));
    rows.push_back(mk(ACT_INSERT, 64'h7, 1, 2, 0));
    rows.push_back(typed(mk(ACT_INVAL, 0, 0, 3, 7), ST_OK, 7, 0, 0));
    rows.push_back(mk(ACT_INVAL, 0, 0, 3, 1));
    rows.push_back(typed(mk(ACT_CLEAR, '1, '1, '1, 7), ST_OK, 0, 0, 0));
    rows.push_back(typed(mk(ACT_LOOKUP, 64'h7, 0, 4, 0), ST_MISS, 0, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      rows.push_back(mk(ACT_INSERT, 64'h10 + i, 100, 9, 0));
    rows.push_back(mk(ACT_INSERT, 64'h10, 100, 9, 0));
    rows.push_back(mk(ACT_INSERT, 64'h12, 50, 10, 0));
    rows.push_back(mk(ACT_LOOKUP, 64'h12, 0, 11, 0));
    rows.push_back(mk(ACT_INVAL, 0, 0, 12, 3));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send(rows[i]);
      maybe_gap();
    end
    drain();

    foreach (pool_set[p]) begin
      write_reg(REG_POOL, pool_set[p]);
      write_reg(REG_MAXOBJ, maxobj_set[p]);
      allow_gaps = (p != 5);
      repeat (85) begin
        send(rand_req());
        maybe_gap();
      end
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

/* lru_variable_size_pool_cache.f */
+incdir+src
src/lvc_pkg.sv
src/lvc_scan.sv
src/lru_variable_size_pool_cache.sv
bench/tb_top.sv
